/* hdl/json_token_lexer_top_defines.svh */
// Assertion macros for the JSON token lexer RTL.
`ifndef JSON_TOKEN_LEXER_TOP_DEFINES_SVH
`define JSON_TOKEN_LEXER_TOP_DEFINES_SVH

// Implication in the same cycle, checked out of reset.
`define JTL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jtl assertion failed");

// Implication in the next cycle, checked out of reset.
`define JTL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jtl assertion failed");

`endif

/* hdl/jtl_pkg.sv */
// Types and constants for the JSON token lexer.
package jtl_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } jtl_in_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] value_byte;
        logic       has_byte;
        logic       bool_value;
        logic       token_end;
        logic [1:0] status;
        logic       result_last;
    } jtl_res_t;

    // Lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    // Token kinds
    localparam logic [3:0] K_CURLY_OPEN  = 4'd0;
    localparam logic [3:0] K_CURLY_CLOSE = 4'd1;
    localparam logic [3:0] K_COLON       = 4'd2;
    localparam logic [3:0] K_NUMBER      = 4'd3;
    localparam logic [3:0] K_STRING      = 4'd4;
    localparam logic [3:0] K_LIST_OPEN   = 4'd5;
    localparam logic [3:0] K_LIST_CLOSE  = 4'd6;
    localparam logic [3:0] K_COMMA       = 4'd7;
    localparam logic [3:0] K_BOOL        = 4'd8;
    localparam logic [3:0] K_NULL        = 4'd9;
    localparam logic [3:0] K_UNKNOWN     = 4'd10;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_END_WS   = 2'd1;
    localparam logic [1:0] ST_END_STR  = 2'd2;

    // Characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;

    // Bytes swallowed after the first letter of a literal
    localparam logic [2:0] SKIP_TRUE_NULL = 3'd3;
    localparam logic [2:0] SKIP_FALSE     = 3'd4;

    // Result queue sizing
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

endpackage

/* hdl/json_token_lexer_top.sv */
// JSON token lexer top level: state registers, decoder and result queue.
//
// Usage:
//  - item channel (item_valid/item_ready/item) carries one byte of JSON text
//    per transaction, with stream_end set on the final byte of a text.
//  - token channel (token_valid/token_ready/token) carries result items; one
//    byte gives zero, one or two results, the last marked by result_last.
//  - Results are registered: token shows the head of the result queue.
//  - Throughput: one byte per cycle while each byte gives at most one result
//    and the receiver keeps up. A byte that gives two results fills the
//    four-entry result queue one step faster than it drains; item_ready
//    drops whenever fewer than two entries are free.
//  - Receiver stall: results wait in the queue, the head held stable on
//    token; item_ready falls once the queue cannot take two more.
//  - Reset: lexer returns to idle between tokens, skip count clears, queue
//    empties. After a byte with stream_end the lexer is idle again, so the
//    next byte starts a new text.
module json_token_lexer_top
    import jtl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  jtl_in_t  item,
    output logic     token_valid,
    input  logic     token_ready,
    output jtl_res_t token
);

`include "json_token_lexer_top_defines.svh"

    logic [1:0] mode_reg, mode_next;
    logic [2:0] skip_reg, skip_next;
    logic [1:0] res_cnt;
    jtl_res_t   res0, res1;
    logic       accept;
    logic       room2;

    assign item_ready = room2;
    assign accept     = item_valid && item_ready;

    // Decode the incoming byte against the current lexer state
    jtl_decode u_decode
    (
        .mode      (mode_reg),
        .skip      (skip_reg),
        .item      (item),
        .mode_next (mode_next),
        .skip_next (skip_next),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    // Hold results until the receiver takes them
    jtl_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (accept ? res_cnt : 2'd0),
        .push0       (res0),
        .push1       (res1),
        .room2       (room2),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

    // Advance lexer state only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            skip_reg <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
        end
    end

    // Skipping always has bytes left to swallow
    `JTL_ASSERT_SAME(a_skip_nonzero, mode_reg == MODE_SKIP, skip_reg != 3'd0)
    // Outside skipping the count stays clear
    `JTL_ASSERT_SAME(a_skip_clear, mode_reg != MODE_SKIP, skip_reg == 3'd0)
    // The final byte of a text leaves the lexer idle
    `JTL_ASSERT_NEXT(a_end_idle, accept && item.stream_end,
                     mode_reg == MODE_IDLE && skip_reg == 3'd0)

endmodule

/* hdl/jtl_decode.sv */
// Single-pass byte decoder: next lexer state and up to two results.
module jtl_decode
    import jtl_pkg::*;
(
    input  logic [1:0] mode,
    input  logic [2:0] skip,
    input  jtl_in_t    item,
    output logic [1:0] mode_next,
    output logic [2:0] skip_next,
    output logic [1:0] res_cnt,
    output jtl_res_t   res0,
    output jtl_res_t   res1
);

    typedef struct packed {
        logic       emit;
        jtl_res_t   res;
        logic [1:0] mode;
        logic [2:0] skip;
    } idle_out_t;

    function automatic jtl_res_t mk(input logic [3:0] kind, input logic [7:0] val,
                                    input logic has, input logic bv,
                                    input logic tend, input logic [1:0] st);
        jtl_res_t r;
        r.token_kind  = kind;
        r.value_byte  = val;
        r.has_byte    = has;
        r.bool_value  = bv;
        r.token_end   = tend;
        r.status      = st;
        r.result_last = 1'b0;
        return r;
    endfunction

    // Handle a byte met between tokens
    function automatic idle_out_t idle_step(input logic [7:0] c, input logic fin);
        idle_out_t o;
        o.emit = 1'b1;
        o.mode = MODE_IDLE;
        o.skip = 3'd0;
        o.res  = mk(K_UNKNOWN, 8'd0, 1'b0, 1'b0, 1'b1, ST_OK);
        if (c inside {CH_SPACE, CH_TAB, CH_LF})
        begin
            o.emit = fin;
            o.res  = mk(K_CURLY_OPEN, 8'd0, 1'b0, 1'b0, 1'b0, ST_END_WS);
        end
        else if (c == CH_QUOTE)
        begin
            o.emit = fin;
            o.res  = mk(K_CURLY_OPEN, 8'd0, 1'b0, 1'b0, 1'b0, ST_END_STR);
            o.mode = fin ? MODE_IDLE : MODE_STR;
        end
        else if (c inside {CH_MINUS, [CH_ZERO:CH_NINE]})
        begin
            o.res  = mk(K_NUMBER, c, 1'b1, 1'b0, fin, ST_OK);
            o.mode = fin ? MODE_IDLE : MODE_NUM;
        end
        else
        begin
            case (c)
                CH_LCURLY: o.res.token_kind = K_CURLY_OPEN;
                CH_RCURLY: o.res.token_kind = K_CURLY_CLOSE;
                CH_LBRACK: o.res.token_kind = K_LIST_OPEN;
                CH_RBRACK: o.res.token_kind = K_LIST_CLOSE;
                CH_COLON:  o.res.token_kind = K_COLON;
                CH_COMMA:  o.res.token_kind = K_COMMA;
                CH_T:
                begin
                    o.res.token_kind = K_BOOL;
                    o.res.bool_value = 1'b1;
                    o.mode           = MODE_SKIP;
                    o.skip           = SKIP_TRUE_NULL;
                end
                CH_F:
                begin
                    o.res.token_kind = K_BOOL;
                    o.mode           = MODE_SKIP;
                    o.skip           = SKIP_FALSE;
                end
                CH_N:
                begin
                    o.res.token_kind = K_NULL;
                    o.mode           = MODE_SKIP;
                    o.skip           = SKIP_TRUE_NULL;
                end
                default: o.res.token_kind = K_UNKNOWN;
            endcase
        end
        return o;
    endfunction

    idle_out_t idle_o;
    logic [7:0] c;
    logic       fin;

    assign c   = item.in_byte;
    assign fin = item.stream_end;
    assign idle_o = idle_step(c, fin);

    always_comb
    begin
        mode_next = mode;
        skip_next = skip;
        res_cnt   = 2'd0;
        res0      = mk(K_CURLY_OPEN, 8'd0, 1'b0, 1'b0, 1'b0, ST_OK);
        res1      = mk(K_CURLY_OPEN, 8'd0, 1'b0, 1'b0, 1'b0, ST_END_STR);
        case (mode)
            MODE_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    res0      = mk(K_STRING, 8'd0, 1'b0, 1'b0, 1'b1, ST_OK);
                    res_cnt   = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    res0    = mk(K_STRING, c, 1'b1, 1'b0, 1'b0, ST_OK);
                    res_cnt = fin ? 2'd2 : 2'd1;
                end
            end
            MODE_NUM:
            begin
                if (c inside {CH_MINUS, CH_DOT, [CH_ZERO:CH_NINE]})
                begin
                    res0    = mk(K_NUMBER, c, 1'b1, 1'b0, fin, ST_OK);
                    res_cnt = 2'd1;
                end
                else
                begin
                    // close the number, then treat the byte as fresh
                    res0      = mk(K_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1, ST_OK);
                    res1      = idle_o.res;
                    res_cnt   = idle_o.emit ? 2'd2 : 2'd1;
                    mode_next = idle_o.mode;
                    skip_next = idle_o.skip;
                end
            end
            MODE_SKIP:
            begin
                if (skip > 3'd1)
                begin
                    skip_next = skip - 3'd1;
                end
                else
                begin
                    skip_next = 3'd0;
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                res0      = idle_o.res;
                res_cnt   = {1'b0, idle_o.emit};
                mode_next = idle_o.mode;
                skip_next = idle_o.skip;
            end
        endcase
        if (fin)
        begin
            mode_next = MODE_IDLE;
            skip_next = 3'd0;
        end
        res0.result_last = (res_cnt == 2'd1);
        res1.result_last = 1'b1;
    end

endmodule

/* hdl/jtl_queue.sv */
// Small result queue: takes up to two results a cycle, delivers one.
module jtl_queue
    import jtl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  jtl_res_t   push0,
    input  jtl_res_t   push1,
    output logic       room2,
    output logic       token_valid,
    input  logic       token_ready,
    output jtl_res_t   token
);

    jtl_res_t          mem [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]      count_reg, count_next;
    logic              pop;
    logic [QAW-1:0]    wr_ptr_p1;

    assign pop         = token_valid && token_ready;
    assign token_valid = (count_reg != '0);
    assign token       = mem[rd_ptr_reg];
    assign room2       = (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign wr_ptr_p1   = wr_ptr_reg + QAW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_p1] <= push1;
        end
    end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the JSON token lexer: byte stream in, token results out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jtl_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_GOAL  = 1950;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED  = 20;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    jtl_in_t  item;
    logic     token_valid;
    logic     token_ready;
    jtl_res_t token;

    json_token_lexer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

    // Lexer state as the testbench sees it, advanced once per accepted byte.
    logic [1:0] lex_state;
    logic [2:0] skip_cnt;
    // Results still owed by the block, oldest first.
    jtl_res_t   expected_tokens[$];

    int err_cnt        = 0;
    int bytes_sent     = 0;
    int active_bytes   = 0;
    int tokens_checked = 0;
    int texts_done     = 0;
    int cyc            = 0;

    // Idle controls shared between the test sequence and the two channel sides.
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int hold_req   = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Count cycles and bail out if the run never drains.
    initial
    begin
        while (cyc <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cyc,
                 expected_tokens.size());
        $display("== FAIL ==");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Token prediction
    //--------------------------------------------------------------------------

    function automatic jtl_res_t mk_token(logic [3:0] kind, logic [7:0] val, logic has,
                                          logic bv, logic tend);
        jtl_res_t r;
        r = '0;
        r.token_kind = kind;
        r.value_byte = val;
        r.has_byte   = has;
        r.bool_value = bv;
        r.token_end  = tend;
        r.status     = ST_OK;
        return r;
    endfunction

    // Status results carry nothing but the status code.
    function automatic jtl_res_t status_token(logic [1:0] st);
        jtl_res_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic bit is_num_char(logic [7:0] c);
        return c == CH_MINUS || c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    // Handle a byte that arrives between tokens; at most one result.
    function automatic void lex_between_tokens(logic [7:0] c, logic last);
        lex_state = MODE_IDLE;
        skip_cnt  = '0;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF)
        begin
            if (last)
                expected_tokens.push_back(status_token(ST_END_WS));
        end
        else if (c == CH_QUOTE)
        begin
            if (last)
                expected_tokens.push_back(status_token(ST_END_STR));
            else
                lex_state = MODE_STR;
        end
        else if (is_num_char(c) && c != CH_DOT)
        begin
            expected_tokens.push_back(mk_token(K_NUMBER, c, 1'b1, 1'b0, last));
            if (!last)
                lex_state = MODE_NUM;
        end
        else
        begin
            case (c)
                CH_LCURLY: expected_tokens.push_back(mk_token(K_CURLY_OPEN, 8'h00, 1'b0, 1'b0, 1'b1));
                CH_RCURLY: expected_tokens.push_back(mk_token(K_CURLY_CLOSE, 8'h00, 1'b0, 1'b0, 1'b1));
                CH_LBRACK: expected_tokens.push_back(mk_token(K_LIST_OPEN, 8'h00, 1'b0, 1'b0, 1'b1));
                CH_RBRACK: expected_tokens.push_back(mk_token(K_LIST_CLOSE, 8'h00, 1'b0, 1'b0, 1'b1));
                CH_COLON:  expected_tokens.push_back(mk_token(K_COLON, 8'h00, 1'b0, 1'b0, 1'b1));
                CH_COMMA:  expected_tokens.push_back(mk_token(K_COMMA, 8'h00, 1'b0, 1'b0, 1'b1));
                CH_T:
                begin
                    expected_tokens.push_back(mk_token(K_BOOL, 8'h00, 1'b0, 1'b1, 1'b1));
                    lex_state = MODE_SKIP;
                    skip_cnt  = SKIP_TRUE_NULL;
                end
                CH_F:
                begin
                    expected_tokens.push_back(mk_token(K_BOOL, 8'h00, 1'b0, 1'b0, 1'b1));
                    lex_state = MODE_SKIP;
                    skip_cnt  = SKIP_FALSE;
                end
                CH_N:
                begin
                    expected_tokens.push_back(mk_token(K_NULL, 8'h00, 1'b0, 1'b0, 1'b1));
                    lex_state = MODE_SKIP;
                    skip_cnt  = SKIP_TRUE_NULL;
                end
                default:   expected_tokens.push_back(mk_token(K_UNKNOWN, 8'h00, 1'b0, 1'b0, 1'b1));
            endcase
        end
    endfunction

    // Advance the lexer by one byte and queue the results it owes.
    // Returns 1 unless the byte was simply skipped over.
    function automatic bit lex_predict(jtl_in_t b);
        int         first;
        logic [1:0] old_state;
        jtl_res_t   tail;
        first     = expected_tokens.size();
        old_state = lex_state;
        case (lex_state)
            MODE_STR:
            begin
                if (b.in_byte == CH_QUOTE)
                begin
                    expected_tokens.push_back(mk_token(K_STRING, 8'h00, 1'b0, 1'b0, 1'b1));
                    lex_state = MODE_IDLE;
                end
                else
                begin
                    expected_tokens.push_back(mk_token(K_STRING, b.in_byte, 1'b1, 1'b0, 1'b0));
                    if (b.stream_end)
                        expected_tokens.push_back(status_token(ST_END_STR));
                end
            end
            MODE_NUM:
            begin
                if (is_num_char(b.in_byte))
                    expected_tokens.push_back(mk_token(K_NUMBER, b.in_byte, 1'b1, 1'b0,
                                                       b.stream_end));
                else
                begin
                    // close the number, then treat the byte as a fresh one
                    expected_tokens.push_back(mk_token(K_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1));
                    lex_between_tokens(b.in_byte, b.stream_end);
                end
            end
            MODE_SKIP:
            begin
                if (skip_cnt > 3'd1)
                    skip_cnt = skip_cnt - 3'd1;
                else
                begin
                    skip_cnt  = '0;
                    lex_state = MODE_IDLE;
                end
            end
            default:   lex_between_tokens(b.in_byte, b.stream_end);
        endcase
        // the final byte of a text always leaves the lexer idle
        if (b.stream_end)
        begin
            lex_state = MODE_IDLE;
            skip_cnt  = '0;
        end
        if (expected_tokens.size() > first)
        begin
            tail = expected_tokens.pop_back();
            tail.result_last = 1'b1;
            expected_tokens.push_back(tail);
        end
        return expected_tokens.size() > first ||
               (old_state == MODE_IDLE && lex_state == MODE_STR);
    endfunction

    //--------------------------------------------------------------------------
    // Checking
    //--------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTED)
            $display("MISMATCH cycle %0d: %s", cyc, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      tokens_checked, name, got, want));
    endtask

    // One process watches both channels at each edge: check the result
    // transaction against the oldest expectation, then feed an accepted byte
    // to the predictor. Results are registered in the block's queue, so the
    // order within the edge does not matter.
    always @(posedge clk)
    begin
        jtl_res_t want;
        if (rst_n)
        begin
            if (token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: kind %0d status %0d",
                                              token.token_kind, token.status));
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", 8'(token.token_kind), 8'(want.token_kind));
                    check_field("value_byte", token.value_byte, want.value_byte);
                    check_field("has_byte", 8'(token.has_byte), 8'(want.has_byte));
                    check_field("bool_value", 8'(token.bool_value), 8'(want.bool_value));
                    check_field("token_end", 8'(token.token_end), 8'(want.token_end));
                    check_field("status", 8'(token.status), 8'(want.status));
                    check_field("result_last", 8'(token.result_last), 8'(want.result_last));
                end
                tokens_checked++;
            end
            if (item_valid && item_ready)
            begin
                bytes_sent++;
                if (lex_predict(item))
                    active_bytes++;
                if (item.stream_end)
                    texts_done++;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Result side: random stall bursts plus an on-demand long hold
    //--------------------------------------------------------------------------

    initial
    begin : token_sink
        int hold_left;
        int burst_left;
        hold_left   = 0;
        burst_left  = 0;
        token_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            // pick up a hold request from the test sequence
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                token_ready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                token_ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(1, 11) - 1;
                token_ready <= 1'b0;
            end
            else
                token_ready <= 1'b1;
        end
    end

    //--------------------------------------------------------------------------
    // Byte side
    //--------------------------------------------------------------------------

    // Offer one byte and hold it until the transaction completes. Called at a
    // clock edge; returns at the edge where the byte was taken, so the next
    // call can keep valid high without dropping it in the same step.
    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= jtl_in_t'{in_byte: c, stream_end: last};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic logic [7:0] rand_num_char(bit allow_dot);
        int k;
        k = $urandom_range(0, allow_dot ? 11 : 10);
        if (k == 10)
            return CH_MINUS;
        if (k == 11)
            return CH_DOT;
        return CH_ZERO + 8'(k);
    endfunction

    // Build one JSON-like text from random tokens and send it. Most tokens are
    // well formed with random content; some are noise, and some texts are cut
    // off at a random byte, so the end can land inside a string, number or literal.
    task automatic lex_random_text();
        logic [7:0] text[$];
        logic [7:0] ws_set[3]    = '{CH_SPACE, CH_TAB, CH_LF};
        logic [7:0] punct_set[6] = '{CH_LCURLY, CH_RCURLY, CH_LBRACK, CH_RBRACK,
                                     CH_COLON, CH_COMMA};
        logic [7:0] c;
        string      tail;
        int         pick;
        pick = $urandom_range(1, 12);
        repeat (pick)
        begin
            case ($urandom_range(0, 9))
                0:
                    repeat ($urandom_range(1, 3)) text.push_back(ws_set[$urandom_range(0, 2)]);
                1, 2:
                    text.push_back(punct_set[$urandom_range(0, 5)]);
                3, 4:
                begin
                    text.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        do
                            c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOTE);
                        text.push_back(c);
                    end
                    text.push_back(CH_QUOTE);
                end
                5, 6:
                begin
                    text.push_back(rand_num_char(1'b0));
                    repeat ($urandom_range(0, 5)) text.push_back(rand_num_char(1'b1));
                end
                7, 8:
                begin
                    case ($urandom_range(0, 2))
                        0:       begin text.push_back(CH_T); tail = "rue";  end
                        1:       begin text.push_back(CH_F); tail = "alse"; end
                        default: begin text.push_back(CH_N); tail = "ull";  end
                    endcase
                    // swallowed bytes: real letters or anything at all
                    for (int i = 0; i < tail.len(); i++)
                        text.push_back($urandom_range(0, 1) ? tail[i] : 8'($urandom_range(0, 255)));
                end
                default:
                    text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       text.push_back(ws_set[$urandom_range(0, 2)]);
            1:       text = text[0:$urandom_range(0, text.size() - 1)];
            default: ;
        endcase
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // All six punctuation tokens, with tab and newline skipped between them.
    task automatic test_punctuation();
        send_byte(CH_LCURLY, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_RCURLY, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_RBRACK, 1'b0);
        send_byte(CH_COLON, 1'b0);
        send_byte(CH_COMMA, 1'b0);
    endtask

    // Null with its full skip, true cut short by the end on its first letter,
    // and false whose skip is ended by the final byte.
    task automatic test_literals();
        send_byte(CH_N, 1'b0);
        send_byte("u", 1'b0);
        send_byte("l", 1'b0);
        send_byte("l", 1'b0);
        send_byte(CH_T, 1'b1);
        send_byte(CH_F, 1'b0);
        send_byte("a", 1'b1);
    endtask

    // String with extreme content bytes, then a text ending on an opening
    // quote and one ending on a content byte.
    task automatic test_strings();
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte("a", 1'b1);
    endtask

    // Number closed by whitespace on the final byte (two results from one
    // byte), a bare dot between tokens, and a number on the final byte.
    task automatic test_numbers();
        send_byte(CH_MINUS, 1'b0);
        send_byte(CH_DOT, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_SPACE, 1'b1);
        send_byte(CH_DOT, 1'b0);
        send_byte(CH_NINE, 1'b1);
    endtask

    // Random texts until the count of bytes sent reaches goal.
    task automatic test_random_texts(int goal, bit tx_idle, bit rx_idle);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        while (bytes_sent < goal)
            lex_random_text();
    endtask

    // Hold the result side off for a long stretch while bytes keep coming,
    // so the result queue fills and the byte side stalls.
    task automatic test_result_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = HOLD_CYCLES;
        repeat (3) lex_random_text();
    endtask

    initial
    begin
        int base;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        lex_state  = MODE_IDLE;
        skip_cnt   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_punctuation();
        test_literals();
        test_strings();
        test_numbers();

        base = bytes_sent;
        test_random_texts(base + RANDOM_GOAL * 3 / 10, 1'b1, 1'b1);
        test_random_texts(base + RANDOM_GOAL * 5 / 10, 1'b1, 1'b0);
        test_random_texts(base + RANDOM_GOAL * 7 / 10, 1'b0, 1'b1);
        test_result_backpressure();
        // last stretch runs flat out on both sides
        test_random_texts(base + RANDOM_GOAL, 1'b0, 1'b0);
        item_valid <= 1'b0;

        // drain outstanding results, then give stray ones time to show up
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("lexed %0d bytes (%0d not skipped) in %0d texts, checked %0d results",
                 bytes_sent, active_bytes, texts_done, tokens_checked);
        $display("directed token cases, random texts with idle bursts and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/jtl_pkg.sv
hdl/jtl_decode.sv
hdl/jtl_queue.sv
hdl/json_token_lexer_top.sv
dv/testbench.sv
